FILE: rtl/bdlp_pkg.sv
package bdlp_pkg;

  // elapsed tick counters, saturating at all ones
  localparam int TICK_W = 17;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W   = 16;
  localparam int OUT_AXIS_W = 12;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_INVERT     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic               pressed;
    logic               flag;
    logic [COUNT_W-1:0] count;
  } press_status_t;

endpackage

FILE: rtl/bdlp_press.sv
module bdlp_press (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        tick,
  input  logic                        button_level,
  input  logic                        ack_long_press,
  input  logic [bdlp_pkg::CFG_W-1:0]  debounce_ms,
  input  logic [bdlp_pkg::CFG_W-1:0]  long_press_ms,
  output bdlp_pkg::press_status_t     status
);
  import bdlp_pkg::*;

  logic               last_raw, last_raw_next;
  logic               stable, stable_next;
  logic [TICK_W-1:0]  since_change, since_change_next;
  logic [TICK_W-1:0]  since_release, since_release_next;
  logic               armed, armed_next;
  logic               pending, pending_next;
  logic [COUNT_W-1:0] total, total_next;
  logic               raw;

  assign raw = ~button_level;

  always_comb begin
    last_raw_next      = last_raw;
    stable_next        = stable;
    armed_next         = armed;
    pending_next       = pending;
    total_next         = total;
    since_change_next  = (&since_change) ? since_change : since_change + 1'b1;
    since_release_next = (&since_release) ? since_release : since_release + 1'b1;

    if (raw != last_raw) begin
      last_raw_next     = raw;
      since_change_next = '0;
    end

    if (since_change_next > TICK_W'(debounce_ms)) begin
      stable_next = raw;
      if (raw && (since_release_next > TICK_W'(long_press_ms))) begin
        if (armed) begin
          total_next   = total + 1'b1;
          armed_next   = 1'b0;
          pending_next = 1'b1;
        end
      end else begin
        armed_next = 1'b1;
      end
      if (!raw) begin
        since_release_next = '0;
      end
    end
  end

  // result reports the flag before this tick's acknowledge
  assign status.pressed = stable_next;
  assign status.flag    = pending_next;
  assign status.count   = total_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw      <= 1'b1;
      stable        <= 1'b0;
      since_change  <= '0;
      since_release <= '0;
      armed         <= 1'b1;
      pending       <= 1'b0;
      total         <= '0;
    end else if (tick) begin
      last_raw      <= last_raw_next;
      stable        <= stable_next;
      since_change  <= since_change_next;
      since_release <= since_release_next;
      armed         <= armed_next;
      pending       <= pending_next & ~ack_long_press;
      total         <= total_next;
    end
  end

endmodule

FILE: rtl/button_debounce_long_press.sv
// Debounced push button with long-press detection and joystick axis pass-through.
// Each input transfer is one millisecond tick carrying the active-low button pin,
// two ADC axis samples and a long-press acknowledge; each produces exactly one
// result transfer. The block takes one tick per clock while the sink keeps up: the
// whole state update is combinational compare and counter logic feeding the result
// register, and a new tick is accepted whenever that register is empty or being
// drained, so the result appears in the cycle after its tick is accepted. The raw
// level becomes the stable state once it has stayed unchanged for more
// than debounce_ms ticks; a stable press seen more than long_press_ms ticks after
// the last stable release sets a sticky flag and bumps a wrapping 16-bit count,
// once per press. Configuration is written through cfg_we/cfg_index/cfg_data
// (0 debounce_ms, 1 long_press_ms, 2 invert_axes; other indexes are ignored) and
// must only change while the block is idle.
module button_debounce_long_press #(
  parameter int ADC_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  // s_axis_tdata: [0] button_level, [12:1] x_sample, [24:13] y_sample,
  // [25] ack_long_press, rest zero
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,
  // m_axis_tdata: [0] pressed, [1] long_press_flag, [17:2] long_press_count,
  // [29:18] x_out, [41:30] y_out, rest zero
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [47:0]                     m_axis_tdata,
  input  logic                            cfg_we,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdlp_pkg::CFG_W-1:0]      cfg_data
);
  import bdlp_pkg::*;

  // working width for the axis math: wide enough for both the sample and ADC range
  localparam int AW = (ADC_BITS > OUT_AXIS_W) ? ADC_BITS : OUT_AXIS_W;
  localparam logic [AW-1:0] ADC_MASK = AW'((64'd1 << ADC_BITS) - 64'd1);

  // configuration registers
  logic [CFG_W-1:0] debounce_ms;
  logic [CFG_W-1:0] long_press_ms;
  logic             invert_axes;

  // input fields
  logic                  button_level;
  logic [OUT_AXIS_W-1:0] x_sample;
  logic [OUT_AXIS_W-1:0] y_sample;
  logic                  ack_long_press;

  logic                  s_xfer;
  press_status_t         status;
  logic [OUT_AXIS_W-1:0] x_axis, y_axis;

  // result register
  logic                  out_valid;
  press_status_t         out_status;
  logic [OUT_AXIS_W-1:0] x_out, y_out;

  // last reported count, only for checking
  logic [COUNT_W-1:0]    rpt_count;

  assign button_level   = s_axis_tdata[0];
  assign x_sample       = s_axis_tdata[12:1];
  assign y_sample       = s_axis_tdata[24:13];
  assign ack_long_press = s_axis_tdata[25];

  // take a new tick when the result slot is free or emptying this cycle
  assign s_axis_tready = ~out_valid | m_axis_tready;
  assign s_xfer        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms   <= DEBOUNCE_RST;
      long_press_ms <= LONG_PRESS_RST;
      invert_axes   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE:   debounce_ms   <= cfg_data;
        REG_LONG_PRESS: long_press_ms <= cfg_data;
        REG_INVERT:     invert_axes   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bdlp_press u_press (
    .clk            (clk),
    .rst            (rst),
    .tick           (s_xfer),
    .button_level   (button_level),
    .ack_long_press (ack_long_press),
    .debounce_ms    (debounce_ms),
    .long_press_ms  (long_press_ms),
    .status         (status)
  );

  // mask to the converter range, optionally invert (max minus sample is an xor
  // once masked), then report the low 12 bits
  always_comb begin
    logic [AW-1:0] xs, ys;
    xs = AW'(x_sample) & ADC_MASK;
    ys = AW'(y_sample) & ADC_MASK;
    if (invert_axes) begin
      xs = xs ^ ADC_MASK;
      ys = ys ^ ADC_MASK;
    end
    x_axis = xs[OUT_AXIS_W-1:0];
    y_axis = ys[OUT_AXIS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rpt_count <= '0;
    end else if (s_xfer) begin
      out_valid <= 1'b1;
      rpt_count <= status.count;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      out_status <= status;
      x_out      <= x_axis;
      y_out      <= y_axis;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, y_out, x_out, out_status.count, out_status.flag,
                          out_status.pressed};

  // an empty result slot never holds off the source
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // the count only moves on a stable press, and then raises the flag
  a_count_needs_press: assert property (@(posedge clk) disable iff (rst)
    (s_xfer && status.count != rpt_count) |-> (status.flag && status.pressed))
    else $error("long-press count moved without a flagged press");

  // the count moves by at most one per tick
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (s_xfer && status.count != rpt_count) |-> status.count == rpt_count + 1'b1)
    else $error("long-press count jumped");

endmodule
